>>> src/tvd_pkg.sv
// tvd_pkg: shared types, constants and helper functions of the turtle drawer
// used by the channel interfaces and by turtle_vector_drawer_2d
`default_nettype none

package tvd_pkg;

  // field widths of the channels
  localparam int unsigned CmdW    = 3;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned StatusW = 2;

  // parameter defaults
  localparam int unsigned StackDepthDef  = 32;
  localparam int unsigned CordicStepsDef = 16;

  // degrees (Q24.8) to binary angle scale, round(2^40 / 360)
  localparam logic [31:0] DegK = 32'd3054198966;
  // cordic start value, limit gain in Q2.30
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // saturation bounds of a coordinate
  localparam logic signed [37:0] SatMax = 38'sd2147483647;
  localparam logic signed [37:0] SatMin = -38'sd2147483648;

  // commands
  typedef enum logic [CmdW-1:0] {
    CMD_ADVANCE  = 3'd0,
    CMD_ROTATE   = 3'd1,
    CMD_SET_HEAD = 3'd2,
    CMD_SET_POS  = 3'd3,
    CMD_PUSH     = 3'd4,
    CMD_POP      = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_NONE  = 2'd0,
    ST_SEG   = 2'd1,
    ST_OVER  = 2'd2,
    ST_UNDER = 2'd3
  } status_e;

  // arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

  // coordinate plus signed step, clamped to the signed 32-bit range
  function automatic logic [31:0] sat_add(input logic [31:0] p, input logic [36:0] d);
    logic signed [37:0] s;
    logic [31:0]        r;
    s = 38'($signed(p)) + 38'($signed(d));
    if (s > SatMax) begin
      r = 32'h7FFF_FFFF;
    end else if (s < SatMin) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/tvd_in_if.sv
// tvd_in_if: command channel of the turtle drawer, valid/ready with payload
// depends on tvd_pkg for the field widths
`default_nettype none

interface tvd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [tvd_pkg::CmdW-1:0]               cmd;
  logic signed [tvd_pkg::CoordW-1:0]      amount;
  logic                                   trace;
  logic signed [tvd_pkg::CoordW-1:0]      new_x;
  logic signed [tvd_pkg::CoordW-1:0]      new_y;

  modport source (output valid, cmd, amount, trace, new_x, new_y, input ready);
  modport sink   (input valid, cmd, amount, trace, new_x, new_y, output ready);
endinterface

`default_nettype wire

>>> src/tvd_out_if.sv
// tvd_out_if: result channel of the turtle drawer, valid/ready with payload
// depends on tvd_pkg for the field widths
`default_nettype none

interface tvd_out_if;
  logic                                   valid;
  logic                                   ready;
  logic [tvd_pkg::StatusW-1:0]            status;
  logic signed [tvd_pkg::CoordW-1:0]      start_x;
  logic signed [tvd_pkg::CoordW-1:0]      start_y;
  logic signed [tvd_pkg::CoordW-1:0]      end_x;
  logic signed [tvd_pkg::CoordW-1:0]      end_y;

  modport source (output valid, status, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, status, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

>>> src/turtle_vector_drawer_2d.sv
// turtle_vector_drawer_2d: two-dimensional turtle engine with state stack
// depends on tvd_pkg, tvd_in_if and tvd_out_if
//
// Usage: commands arrive as beats on in_i (advance, rotate, set heading,
// set position, push, pop, clear) and every command returns exactly one
// result beat on out_o with a status and, for a traced advance, the
// segment start and end points. The block takes one command at a time:
// in_i.ready is high only while the sequencer is idle.
// Steps from the accepting edge to out_o.valid: an advance runs the
// cordic iterations, then a multiply (S_MUL) and accumulate (S_ACC) for
// x and again for y; rotate and set heading pass S_MUL and S_ACC once;
// all other commands pass S_EXEC. Each then waits in S_DONE for the
// output register. The cordic iterations run on one shared shift/add
// unit; one shared multiplier serves the degree conversion and both step
// products, one product at a time.
// The result sits in an output register; a stalled receiver does not block
// the next command, but a finished result waits in the sequencer until the
// output register is free. Reset clears position, heading and stack level;
// stack entries are not cleared, as only saved entries are ever read back.
`default_nettype none

module turtle_vector_drawer_2d #(
  parameter int unsigned STACK_DEPTH  = tvd_pkg::StackDepthDef,
  parameter int unsigned CORDIC_STEPS = tvd_pkg::CordicStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tvd_in_if.sink    in_i,
  tvd_out_if.source out_o
);
  import tvd_pkg::*;

  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);
  localparam int unsigned ItW  = $clog2(CORDIC_STEPS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CORDIC = 6'b000010,
    S_MUL    = 6'b000100,
    S_ACC    = 6'b001000,
    S_EXEC   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // turtle state
  logic [31:0]     pos_x_q, pos_y_q, heading_q;
  logic [LvlW-1:0] level_q;

  // latched command
  logic [CmdW-1:0] cmd_q;
  logic [31:0]     amount_q, nx_q, ny_q;
  logic            trace_q;

  // cordic unit
  logic signed [33:0] x_q, y_q, z_q;
  logic [ItW-1:0]     iter_q;
  logic               flip_q;
  logic               axis_q;

  // shared multiplier
  logic signed [66:0] prod_q;

  // pending result and output register
  logic [StatusW-1:0] res_status_q, out_status_q;
  logic [31:0]        res_sx_q, res_sy_q, res_ex_q, res_ey_q;
  logic [31:0]        out_sx_q, out_sy_q, out_ex_q, out_ey_q;
  logic [31:0]        new_x_q;
  logic               out_valid_q;

  // stack memory, {x, y, heading} per entry
  logic [95:0]     stack_mem [STACK_DEPTH];
  logic [95:0]     rd_q;
  logic [IdxW-1:0] rd_idx, wr_idx;
  logic            push_we;

  logic in_acc, out_free, stack_full, stack_empty;

  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign stack_full  = (level_q == LvlW'(STACK_DEPTH));
  assign stack_empty = (level_q == '0);

  // handshake and result ports
  assign in_i.ready    = (state_q == S_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.status  = out_status_q;
  assign out_o.start_x = out_sx_q;
  assign out_o.start_y = out_sy_q;
  assign out_o.end_x   = out_ex_q;
  assign out_o.end_y   = out_ey_q;

  // heading in the left half plane is turned by half a turn first
  logic        flip_in;
  logic [31:0] z_init;
  assign flip_in = (heading_q[31:30] == 2'b01) || (heading_q[31:30] == 2'b10);
  assign z_init  = {heading_q[31] ^ flip_in, heading_q[30:0]};

  // one cordic micro-rotation
  logic signed [33:0] xs, ys, at, x_n, y_n, z_n;
  logic               last_iter;
  always_comb begin
    xs = x_q >>> iter_q;
    ys = y_q >>> iter_q;
    at = $signed({2'b00, atan_angle(5'(iter_q))});
    if (!z_q[33]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - at;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + at;
    end
  end
  assign last_iter = (iter_q == ItW'(CORDIC_STEPS - 1));

  // multiplier operand selection
  logic               deg_mode;
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  assign deg_mode = (cmd_q != CMD_ADVANCE);
  always_comb begin
    if (deg_mode) begin
      mul_a = 34'($signed(amount_q));
      mul_b = $signed({1'b0, DegK});
    end else begin
      mul_a = axis_q ? y_q : x_q;
      mul_b = 33'($signed(amount_q));
    end
  end

  // product post-processing: rounded angle and rounded step
  logic [47:0]        deg_sum;
  logic [31:0]        angle;
  logic signed [66:0] step_sum;
  logic [36:0]        step;
  logic [31:0]        sat_q_w;
  assign deg_sum  = prod_q[47:0] + 48'h8000;
  assign angle    = deg_sum[47:16];
  assign step_sum = prod_q + 67'sd536870912;
  assign step     = step_sum[66:30];
  assign sat_q_w  = sat_add(axis_q ? pos_y_q : pos_x_q, step);

  // stack addressing
  assign rd_idx  = stack_empty ? '0 : IdxW'(level_q - 1'b1);
  assign wr_idx  = IdxW'(level_q);
  assign push_we = (state_q == S_EXEC) && (cmd_q == CMD_PUSH) && !stack_full;

  always_ff @(posedge clk_i) begin
    if (push_we) begin
      stack_mem[wr_idx] <= {pos_x_q, pos_y_q, heading_q};
    end
    rd_q <= stack_mem[rd_idx];
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_i.cmd)
            CMD_ADVANCE:              state_d = S_CORDIC;
            CMD_ROTATE, CMD_SET_HEAD: state_d = S_MUL;
            default:                  state_d = S_EXEC;
          endcase
        end
      end
      S_CORDIC: if (last_iter) state_d = S_MUL;
      S_MUL:    state_d = S_ACC;
      S_ACC: begin
        state_d = (!deg_mode && !axis_q) ? S_MUL : S_DONE;
      end
      S_EXEC:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // control state and turtle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      level_q     <= '0;
      iter_q      <= '0;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // cordic step counter
      if (state_q == S_CORDIC) begin
        iter_q <= last_iter ? '0 : iter_q + 1'b1;
      end
      if (state_q == S_IDLE) begin
        axis_q <= 1'b0;
      end

      // step product applied, or angle applied
      if (state_q == S_ACC) begin
        if (!deg_mode) begin
          axis_q <= 1'b1;
          if (axis_q) begin
            pos_x_q <= new_x_q;
            pos_y_q <= sat_q_w;
          end
        end else if (cmd_q == CMD_ROTATE) begin
          heading_q <= heading_q + angle;
        end else begin
          heading_q <= angle;
        end
      end

      // commands without arithmetic
      if (state_q == S_EXEC) begin
        case (cmd_q)
          CMD_SET_POS: begin
            pos_x_q <= nx_q;
            pos_y_q <= ny_q;
          end
          CMD_PUSH: if (!stack_full) level_q <= level_q + 1'b1;
          CMD_POP: begin
            if (!stack_empty) begin
              level_q   <= level_q - 1'b1;
              pos_x_q   <= rd_q[95:64];
              pos_y_q   <= rd_q[63:32];
              heading_q <= rd_q[31:0];
            end
          end
          CMD_CLEAR: begin
            pos_x_q   <= '0;
            pos_y_q   <= '0;
            heading_q <= '0;
            level_q   <= '0;
          end
          default: ;
        endcase
      end

      // output register
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q    <= in_i.cmd;
      amount_q <= in_i.amount;
      trace_q  <= in_i.trace;
      nx_q     <= in_i.new_x;
      ny_q     <= in_i.new_y;
      x_q      <= CordicGain;
      y_q      <= '0;
      z_q      <= 34'($signed(z_init));
      flip_q   <= flip_in;
    end

    // cordic iteration, result negated back for a flipped heading
    if (state_q == S_CORDIC) begin
      if (last_iter && flip_q) begin
        x_q <= -x_n;
        y_q <= -y_n;
      end else begin
        x_q <= x_n;
        y_q <= y_n;
      end
      z_q <= z_n;
    end

    if (state_q == S_MUL) begin
      prod_q <= mul_a * mul_b;
    end

    // pending result
    if (state_q == S_ACC) begin
      if (!deg_mode && !axis_q) begin
        new_x_q <= sat_q_w;
      end else if (!deg_mode && trace_q) begin
        res_status_q <= ST_SEG;
        res_sx_q     <= pos_x_q;
        res_sy_q     <= pos_y_q;
        res_ex_q     <= new_x_q;
        res_ey_q     <= sat_q_w;
      end else begin
        res_status_q <= ST_NONE;
        res_sx_q     <= '0;
        res_sy_q     <= '0;
        res_ex_q     <= '0;
        res_ey_q     <= '0;
      end
    end

    if (state_q == S_EXEC) begin
      res_sx_q <= '0;
      res_sy_q <= '0;
      res_ex_q <= '0;
      res_ey_q <= '0;
      if (cmd_q == CMD_PUSH && stack_full) begin
        res_status_q <= ST_OVER;
      end else if (cmd_q == CMD_POP && stack_empty) begin
        res_status_q <= ST_UNDER;
      end else begin
        res_status_q <= ST_NONE;
      end
    end

    if (state_q == S_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_sx_q     <= res_sx_q;
      out_sy_q     <= res_sy_q;
      out_ex_q     <= res_ex_q;
      out_ey_q     <= res_ey_q;
    end
  end

  // checks on the sequencer and stack
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_iter_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (iter_q != '0) |-> (state_q == S_CORDIC))
    else $error("cordic counter running outside rotation");

  a_coords_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_SEG) |->
      (out_sx_q == '0 && out_sy_q == '0 && out_ex_q == '0 && out_ey_q == '0))
    else $error("coordinates set on a result without segment");

  a_underflow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q == CMD_POP && stack_empty) |=>
      ($stable(level_q) && $stable(heading_q) && $stable(pos_x_q)))
    else $error("refused pop changed the turtle");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !out_valid_q) |=> out_valid_q)
    else $error("finished result not presented");

endmodule

`default_nettype wire

>>> tb/tb_turtle_vector_drawer_2d.sv
// tb_turtle_vector_drawer_2d: self-checking bench for the 2d turtle engine
// depends on tvd_pkg, tvd_in_if, tvd_out_if and turtle_vector_drawer_2d
// a mirror of the turtle state predicts every result beat, checked in order

module tb_turtle_vector_drawer_2d;
  timeunit 1ns;
  timeprecision 1ps;

  import tvd_pkg::*;

  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 4;
  localparam int          PhaseItems  = 600;
  localparam int          HoldCycles  = 150;
  localparam int          DrainCycles = 50;
  localparam int          WatchLimit  = 3000;
  localparam int          Deg         = 256;
  localparam logic [2:0]  CmdUnused   = 3'd7;

  // one expected result beat
  typedef struct {
    logic [1:0]  status;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] end_x;
    logic [31:0] end_y;
  } segment_t;

  // shadow turtle: position, heading and saved states, plus the segments owed
  class turtle_mirror;
    localparam int          StackDepth  = 32;
    localparam int          CordicSteps = 16;
    localparam int          MaxReports  = 10;
    localparam longint      DegScale    = 64'sd3054198966;
    localparam longint      UnitGain    = 64'sd652032874;
    localparam longint      Half        = 64'sd536870912;
    localparam logic [31:0] AtanStep [CordicSteps] = '{
      32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
      32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
      32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
      32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
    };

    logic [31:0] pos_x, pos_y, heading;
    logic [31:0] saved_x [StackDepth];
    logic [31:0] saved_y [StackDepth];
    logic [31:0] saved_heading [StackDepth];
    int          depth;
    segment_t    pending_segments [$];
    int          mismatches;
    int          results_seen;

    function new();
      pos_x        = '0;
      pos_y        = '0;
      heading      = '0;
      depth        = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function int outstanding();
      return pending_segments.size();
    endfunction

    // degrees in Q24.8 to binary angle, rounded half up
    function logic [31:0] to_angle(logic [31:0] amt);
      longint p;
      p = longint'($signed(amt)) * DegScale + 64'sd32768;
      return p[47:16];
    endfunction

    // cordic rotation, left half plane folded over by half a turn
    function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
      logic        flip;
      logic [31:0] a;
      longint      x, y, z, xs, ys;
      flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
      a    = flip ? ang + 32'h8000_0000 : ang;
      z    = longint'($signed(a));
      x    = UnitGain;
      y    = 0;
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(AtanStep[i]);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(AtanStep[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // coordinate plus step, clamped to the signed 32-bit range
    function logic [31:0] clamp_add(logic [31:0] p, longint step);
      longint v;
      v = longint'($signed(p)) + step;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    // apply one accepted command and queue the result it owes
    function void take_command(logic [2:0] op, logic [31:0] amt, logic tr,
                               logic [31:0] nx, logic [31:0] ny);
      segment_t    seg;
      longint      c, s, d;
      logic [31:0] old_x, old_y;
      seg = '{default: '0};
      seg.status = ST_NONE;
      case (op)
        CMD_ADVANCE: begin
          old_x = pos_x;
          old_y = pos_y;
          sin_cos(heading, c, s);
          d     = longint'($signed(amt));
          pos_x = clamp_add(pos_x, (c * d + Half) >>> 30);
          pos_y = clamp_add(pos_y, (s * d + Half) >>> 30);
          if (tr) begin
            seg.status  = ST_SEG;
            seg.start_x = old_x;
            seg.start_y = old_y;
            seg.end_x   = pos_x;
            seg.end_y   = pos_y;
          end
        end
        CMD_ROTATE:   heading = heading + to_angle(amt);
        CMD_SET_HEAD: heading = to_angle(amt);
        CMD_SET_POS: begin
          pos_x = nx;
          pos_y = ny;
        end
        CMD_PUSH: begin
          if (depth >= StackDepth) begin
            seg.status = ST_OVER;
          end else begin
            saved_x[depth]       = pos_x;
            saved_y[depth]       = pos_y;
            saved_heading[depth] = heading;
            depth++;
          end
        end
        CMD_POP: begin
          if (depth == 0) begin
            seg.status = ST_UNDER;
          end else begin
            depth--;
            pos_x   = saved_x[depth];
            pos_y   = saved_y[depth];
            heading = saved_heading[depth];
          end
        end
        CMD_CLEAR: begin
          pos_x   = '0;
          pos_y   = '0;
          heading = '0;
          depth   = 0;
        end
        default: ;
      endcase
      pending_segments.push_back(seg);
    endfunction

    // compare one result beat with the oldest segment owed
    function void match_result(logic [1:0] st, logic [31:0] sx, logic [31:0] sy,
                               logic [31:0] ex, logic [31:0] ey);
      segment_t want;
      results_seen++;
      if (pending_segments.size() == 0) begin
        if (mismatches < MaxReports)
          $display("result %0d: nothing outstanding, got status %0d start %h,%h end %h,%h",
                   results_seen, st, sx, sy, ex, ey);
        mismatches++;
        return;
      end
      want = pending_segments.pop_front();
      if (want.status !== st || want.start_x !== sx || want.start_y !== sy ||
          want.end_x !== ex || want.end_y !== ey) begin
        if (mismatches < MaxReports) begin
          $display("result %0d: expected status %0d start %h,%h end %h,%h",
                   results_seen, want.status, want.start_x, want.start_y,
                   want.end_x, want.end_y);
          $display("result %0d: actual   status %0d start %h,%h end %h,%h",
                   results_seen, st, sx, sy, ex, ey);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni;
  turtle_mirror turtle;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           commands_sent;
  int           hold_left;
  logic         hold_req;

  tvd_in_if  cmd_if ();
  tvd_out_if res_if ();

  turtle_vector_drawer_2d DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  // clock
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // random distance: mostly moderate, some extremes and full-range words
  function automatic logic [31:0] rand_distance();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(3))
          0:       v = 32'h7FFF_FFFF;
          1:       v = 32'h8000_0000;
          2:       v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: v = $urandom_range(32'h0080_0000) - 32'h0040_0000;
    endcase
    return v;
  endfunction

  // random degrees in Q24.8: multiples of 45 degrees, moderate turns, any word
  function automatic logic [31:0] rand_degrees();
    logic [31:0] v;
    case ($urandom_range(5))
      0:       v = $urandom;
      1:       v = 45 * Deg * $urandom_range(16) - 360 * Deg;
      default: v = $urandom_range(2 * 720 * Deg) - 720 * Deg;
    endcase
    return v;
  endfunction

  // random coordinate, sometimes close to the saturation bounds
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(5))
      0:       v = $urandom;
      1:       v = 32'h7FF0_0000 + $urandom_range(32'h000F_FFFF);
      2:       v = 32'h8000_0000 + $urandom_range(32'h000F_FFFF);
      default: v = $urandom_range(32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  // offer one command beat, idling at random first, and wait for acceptance
  task automatic issue(input logic [2:0] op, input logic [31:0] amt, input logic tr,
                       input logic [31:0] nx, input logic [31:0] ny);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid  = 1'b1;
    cmd_if.cmd    = op;
    cmd_if.amount = amt;
    cmd_if.trace  = tr;
    cmd_if.new_x  = nx;
    cmd_if.new_y  = ny;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op != CmdUnused) commands_sent++;
  endtask

  // long receiver hold-off, counted here
  initial begin
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end else if (hold_left > 0) begin
        hold_left--;
      end
    end
  end

  // result side ready
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // beat monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready)
        turtle.take_command(cmd_if.cmd, cmd_if.amount, cmd_if.trace,
                            cmd_if.new_x, cmd_if.new_y);
      if (res_if.valid && res_if.ready)
        turtle.match_result(res_if.status, res_if.start_x, res_if.start_y,
                            res_if.end_x, res_if.end_y);
    end
  end

  // watchdog on cycles without any beat
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WatchLimit) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("tb_turtle_vector_drawer_2d: errors");
    $finish;
  end

  // stimulus
  initial begin
    int target;
    int pick;
    int burst;
    turtle        = new();
    rst_ni        = 1'b0;
    hold_req      = 1'b0;
    commands_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = CMD_CLEAR;
    cmd_if.amount = '0;
    cmd_if.trace  = 1'b0;
    cmd_if.new_x  = '0;
    cmd_if.new_y  = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      // sender idles lightly and receiver heavily, then swapped, then neither
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      // directed: empty pop, unused command, extremes, saturation, wrap
      if (phase == 0) begin
        issue(CMD_POP, '0, 1'b0, '0, '0);
        issue(CmdUnused, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(CMD_ADVANCE, 32'h0001_0000, 1'b1, '0, '0);
        issue(CMD_SET_HEAD, 90 * Deg, 1'b0, '0, '0);
        issue(CMD_ADVANCE, 32'h7FFF_FFFF, 1'b1, '0, '0);
        issue(CMD_ROTATE, 180 * Deg, 1'b1, '0, '0);
        issue(CMD_ADVANCE, 32'h8000_0000, 1'b1, '0, '0);
        issue(CMD_SET_HEAD, -45 * Deg, 1'b0, '0, '0);
        issue(CMD_ROTATE, 32'h7FFF_FFFF, 1'b0, '0, '0);
        issue(CMD_ADVANCE, 32'h0100_0000, 1'b1, '0, '0);
        issue(CMD_SET_HEAD, 32'h8000_0000, 1'b0, '0, '0);
        issue(CMD_ADVANCE, 32'h0100_0000, 1'b1, '0, '0);
        issue(CMD_SET_POS, '0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        issue(CMD_SET_HEAD, 30 * Deg, 1'b0, '0, '0);
        issue(CMD_ADVANCE, 32'h7FFF_FFFF, 1'b1, '0, '0);
        issue(CMD_SET_POS, '0, 1'b0, 32'h8000_0000, 32'h8000_0000);
        issue(CMD_ADVANCE, 32'h8000_0000, 1'b1, '0, '0);
        issue(CMD_PUSH, '0, 1'b0, '0, '0);
        issue(CMD_SET_HEAD, 135 * Deg, 1'b0, '0, '0);
        issue(CMD_ADVANCE, 32'h0050_0000, 1'b0, '0, '0);
        issue(CMD_POP, '0, 1'b0, '0, '0);
        issue(CMD_ADVANCE, '0, 1'b1, '0, '0);
        issue(CMD_ROTATE, -720 * Deg, 1'b0, '0, '0);
        issue(CMD_CLEAR, '0, 1'b1, '0, '0);
        issue(CMD_ADVANCE, 32'h0002_8000, 1'b1, '0, '0);
      end

      // receiver stalls for a long stretch while commands keep coming
      if (phase != 1) hold_req = 1'b1;

      // random turtle programs with some noise
      target = commands_sent + PhaseItems;
      while (commands_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 35) begin
          // branch: save, turn, draw, restore
          issue(CMD_PUSH, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
          issue(CMD_ROTATE, rand_degrees(), 1'($urandom_range(1)), $urandom, $urandom);
          repeat ($urandom_range(1, 3))
            issue(CMD_ADVANCE, rand_distance(), $urandom_range(3) != 0, $urandom, $urandom);
          issue(CMD_POP, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
        end else if (pick < 60) begin
          // walk: set heading, then strides and turns
          issue(CMD_SET_HEAD, rand_degrees(), 1'($urandom_range(1)), $urandom, $urandom);
          repeat ($urandom_range(1, 6)) begin
            issue(CMD_ADVANCE, rand_distance(), $urandom_range(3) != 0, $urandom, $urandom);
            if ($urandom_range(1))
              issue(CMD_ROTATE, rand_degrees(), 1'($urandom_range(1)), $urandom, $urandom);
          end
        end else if (pick < 72) begin
          // jump and stride, often into saturation
          issue(CMD_SET_POS, $urandom, 1'($urandom_range(1)), rand_coord(), rand_coord());
          issue(CMD_ADVANCE, rand_distance(), 1'b1, $urandom, $urandom);
        end else if (pick < 74) begin
          // fill the stack, at times past full, then pop one more than was pushed
          burst = $urandom_range(30, 36);
          repeat (burst)
            issue(CMD_PUSH, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
          repeat (burst + 1)
            issue(CMD_POP, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
        end else if (pick < 78) begin
          issue(CMD_CLEAR, $urandom, 1'($urandom_range(1)), $urandom, $urandom);
        end else begin
          issue(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)), $urandom, $urandom);
        end
      end

      // sender pauses until every result has come back
      cmd_if.valid = 1'b0;
      do @(negedge clk_i); while (turtle.outstanding() != 0);
    end

    repeat (DrainCycles) @(negedge clk_i);
    if (turtle.mismatches == 0 && turtle.outstanding() == 0)
      $display("tb_turtle_vector_drawer_2d: clean");
    else
      $display("tb_turtle_vector_drawer_2d: errors");
    $finish;
  end

endmodule
